// File: rtl/core/frm_pkg.sv
// Shared types and constants for the frame rate meter.
// No dependencies; imported by every module of the block.
`default_nettype none

package frm_pkg;

    localparam int FRAME_W     = 24;
    localparam int TALLY_W     = 20;
    localparam int PSUM_W      = 25;
    localparam int FPS_FRAC_W  = 8;
    localparam int NUM_W       = 2 * TALLY_W + FPS_FRAC_W;
    localparam int DVS_W       = 25;
    localparam int CNT_W       = 6;
    localparam int CFG_IDX_W   = 2;

    localparam int HISTORY_DEPTH_DEF = 16;

    localparam logic [FRAME_W-1:0] RESET_DEFAULT_US = 24'd33333;
    localparam logic [FRAME_W-1:0] RESET_CLAMP_US   = 24'd1000000;
    localparam logic [FRAME_W-1:0] RESET_PERIOD_US  = 24'd1000000;

    localparam logic [TALLY_W-1:0] TALLY_MAX = '1;
    localparam logic [TALLY_W-1:0] US_PER_S  = 20'd1000000;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DEFAULT_FRAME = 2'd0,
        CFG_CLAMP_LIMIT   = 2'd1,
        CFG_PERIOD        = 2'd2
    } cfg_index_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_READ,
        ST_UPDATE,
        ST_AVG,
        ST_MUL,
        ST_FPS_START,
        ST_FPS_RUN,
        ST_MEAN_START,
        ST_MEAN_RUN,
        ST_OUTPUT
    } state_t;

    typedef struct packed {
        logic             start;
        logic [CNT_W-1:0] count;
    } div_ctrl_t;

    typedef struct packed {
        logic               done;
        logic [FRAME_W-1:0] quotient;
    } div_stat_t;

endpackage

`default_nettype wire

// File: rtl/core/frm_div.sv
// Shared radix-2 restoring divider, one quotient bit per cycle.
// Quotient saturates at 24 bits. Depends on frm_pkg.
`default_nettype none

module frm_div (
    input  wire logic                     aclk,
    input  wire logic                     aresetn,
    input  wire frm_pkg::div_ctrl_t       ctrl,
    input  wire logic [frm_pkg::NUM_W-1:0] numerator,
    input  wire logic [frm_pkg::DVS_W-1:0] divisor,
    output frm_pkg::div_stat_t            stat
);
    import frm_pkg::*;

    logic             busy_reg;
    logic             done_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [NUM_W-1:0] quo_reg;
    logic [DVS_W-1:0] rem_reg;
    logic [DVS_W-1:0] dvs_reg;

    logic [DVS_W:0]   shifted;
    logic [DVS_W:0]   diff;
    logic             fits;

    always_comb begin
        shifted = {rem_reg, quo_reg[NUM_W-1]};
        diff    = shifted - {1'b0, dvs_reg};
        fits    = shifted >= {1'b0, dvs_reg};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else if (ctrl.start) begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= ctrl.count;
        end else if (busy_reg) begin
            cnt_reg <= cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1)) begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end else begin
            done_reg <= 1'b0;
        end
    end

    // numerator arrives left-aligned, so after count steps the low bits hold the quotient
    always_ff @(posedge aclk) begin
        if (ctrl.start) begin
            rem_reg <= '0;
            quo_reg <= numerator;
            dvs_reg <= divisor;
        end else if (busy_reg) begin
            rem_reg <= fits ? diff[DVS_W-1:0] : shifted[DVS_W-1:0];
            quo_reg <= {quo_reg[NUM_W-2:0], fits};
        end
    end

    always_comb begin
        stat.done     = done_reg;
        stat.quotient = (|quo_reg[NUM_W-1:FRAME_W]) ? '1 : quo_reg[FRAME_W-1:0];
    end

endmodule

`default_nettype wire

// File: rtl/core/frm_hist.sv
// Frame time history ring: memory with registered read and per-entry valid bits.
// Entries never written read as the reset default frame time. Depends on frm_pkg.
`default_nettype none

module frm_hist #(
    parameter int DEPTH = frm_pkg::HISTORY_DEPTH_DEF,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic                       rd_en,
    input  wire logic [AW-1:0]              rd_addr,
    input  wire logic                       wr_en,
    input  wire logic [AW-1:0]              wr_addr,
    input  wire logic [frm_pkg::FRAME_W-1:0] wr_data,
    output logic      [frm_pkg::FRAME_W-1:0] rd_data
);
    import frm_pkg::*;

    logic [FRAME_W-1:0] mem [DEPTH];
    logic [DEPTH-1:0]   valid_reg;
    logic [FRAME_W-1:0] rd_data_reg;
    logic               rd_valid_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg  <= mem[rd_addr];
            rd_valid_reg <= valid_reg[rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (wr_en) begin
            valid_reg[wr_addr] <= 1'b1;
        end
    end

    assign rd_data = rd_valid_reg ? rd_data_reg : RESET_DEFAULT_US;

endmodule

`default_nettype wire

// File: rtl/core/frame_rate_meter_unit.sv
// Frame rate meter top level: sequencer around one shared divider and the history ring.
// Per frame: read the evicted entry, update window and period sums, form the average;
// a frame that closes a period adds a 20x20 multiply and 48-step and 25-step divisions.
// One request in flight: next accept once the output register loads, later if m_ready stalls.
// Synchronous active-low reset presets the history and window sum to the 33333 us default.
// Depends on frm_pkg, frm_div, frm_hist.
`default_nettype none

module frame_rate_meter_unit #(
    parameter int HISTORY_DEPTH = frm_pkg::HISTORY_DEPTH_DEF
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          s_valid,
    output logic                               s_ready,
    input  wire logic [frm_pkg::FRAME_W-1:0]   s_frame_us,
    output logic                               m_valid,
    input  wire logic                          m_ready,
    output logic      [frm_pkg::FRAME_W-1:0]   m_avg_delta_us,
    output logic      [frm_pkg::FRAME_W-1:0]   m_fps_q8,
    output logic      [frm_pkg::FRAME_W-1:0]   m_mean_frame_us,
    output logic                               m_period_done,
    input  wire logic                          cfg_valid,
    output logic                               cfg_ready,
    input  wire logic [frm_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [frm_pkg::FRAME_W-1:0]   cfg_data
);
    import frm_pkg::*;

    localparam int AW  = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
    localparam int LOG_D = $clog2(HISTORY_DEPTH);
    localparam int WSW = FRAME_W + LOG_D;
    localparam logic [WSW-1:0] WSUM_RESET = WSW'(HISTORY_DEPTH) * WSW'(RESET_DEFAULT_US);
    // reciprocal of the depth, exact for sums below HISTORY_DEPTH * 2^24
    localparam int AVG_SHIFT = FRAME_W + 2 * LOG_D;
    localparam int RCP_W     = FRAME_W + LOG_D + 1;
    localparam int PROD_W    = WSW + RCP_W;
    localparam logic [RCP_W-1:0] AVG_RECIP =
        RCP_W'(((64'd1 << AVG_SHIFT) + 64'(HISTORY_DEPTH) - 64'd1) / 64'(HISTORY_DEPTH));

    state_t state_reg, state_next;

    logic [FRAME_W-1:0]   default_us_reg;
    logic [FRAME_W-1:0]   clamp_us_reg;
    logic [FRAME_W-1:0]   period_us_reg;

    logic [WSW-1:0]       window_sum_reg;
    logic [AW-1:0]        slot_reg;
    logic [PSUM_W-1:0]    psum_reg;
    logic [TALLY_W-1:0]   tally_reg;
    logic [FRAME_W-1:0]   rate_reg;
    logic [FRAME_W-1:0]   mean_reg;

    logic [FRAME_W-1:0]   frame_reg;
    logic [FRAME_W-1:0]   avg_reg;
    logic [2*TALLY_W-1:0] product_reg;
    logic                 close_reg;

    logic                 m_valid_reg;
    logic [FRAME_W-1:0]   m_avg_reg;
    logic [FRAME_W-1:0]   m_fps_reg;
    logic [FRAME_W-1:0]   m_mean_reg;
    logic                 m_done_reg;

    logic                 in_accept;
    logic                 out_free;
    logic [FRAME_W-1:0]   old_entry;
    logic [FRAME_W-1:0]   stored;
    logic [PSUM_W:0]      psum_sum;
    logic [PSUM_W-1:0]    psum_new;
    logic [TALLY_W-1:0]   tally_new;
    logic [PROD_W-1:0]    avg_prod;
    logic [FRAME_W-1:0]   avg_calc;

    div_ctrl_t            div_ctrl;
    div_stat_t            div_stat;
    logic [NUM_W-1:0]     div_num;
    logic [DVS_W-1:0]     div_dvs;

    assign s_ready   = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign in_accept = s_valid && s_ready;
    assign out_free  = !m_valid_reg || m_ready;

    frm_hist #(
        .DEPTH (HISTORY_DEPTH),
        .AW    (AW)
    ) u_hist (
        .aclk    (aclk),
        .aresetn (aresetn),
        .rd_en   (in_accept),
        .rd_addr (slot_reg),
        .wr_en   (state_reg == ST_UPDATE),
        .wr_addr (slot_reg),
        .wr_data (stored),
        .rd_data (old_entry)
    );

    frm_div u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ctrl      (div_ctrl),
        .numerator (div_num),
        .divisor   (div_dvs),
        .stat      (div_stat)
    );

    // per-frame update terms
    always_comb begin
        stored    = (frame_reg > clamp_us_reg) ? default_us_reg : frame_reg;
        psum_sum  = {1'b0, psum_reg} + (PSUM_W+1)'(frame_reg);
        psum_new  = psum_sum[PSUM_W] ? '1 : psum_sum[PSUM_W-1:0];
        tally_new = (tally_reg == TALLY_MAX) ? tally_reg : tally_reg + 1'b1;
        avg_prod  = PROD_W'(window_sum_reg) * PROD_W'(AVG_RECIP);
        avg_calc  = avg_prod[AVG_SHIFT +: FRAME_W];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next     = state_reg;
        div_ctrl.start = 1'b0;
        div_ctrl.count = '0;
        div_num        = '0;
        div_dvs        = '0;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    state_next = ST_READ;
                end
            end
            ST_READ:   state_next = ST_UPDATE;
            ST_UPDATE: state_next = ST_AVG;
            ST_AVG:    state_next = close_reg ? ST_MUL : ST_OUTPUT;
            ST_MUL:    state_next = ST_FPS_START;
            ST_FPS_START: begin
                div_ctrl.start = 1'b1;
                div_ctrl.count = CNT_W'(NUM_W);
                div_num        = {product_reg, {FPS_FRAC_W{1'b0}}};
                div_dvs        = DVS_W'(psum_reg);
                state_next     = ST_FPS_RUN;
            end
            ST_FPS_RUN: begin
                if (div_stat.done) begin
                    state_next = ST_MEAN_START;
                end
            end
            ST_MEAN_START: begin
                div_ctrl.start = 1'b1;
                div_ctrl.count = CNT_W'(PSUM_W);
                div_num        = {psum_reg, {(NUM_W-PSUM_W){1'b0}}};
                div_dvs        = DVS_W'(tally_reg);
                state_next     = ST_MEAN_RUN;
            end
            ST_MEAN_RUN: begin
                if (div_stat.done) begin
                    state_next = ST_OUTPUT;
                end
            end
            ST_OUTPUT: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            default_us_reg <= RESET_DEFAULT_US;
            clamp_us_reg   <= RESET_CLAMP_US;
            period_us_reg  <= RESET_PERIOD_US;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                CFG_DEFAULT_FRAME: default_us_reg <= cfg_data;
                CFG_CLAMP_LIMIT:   clamp_us_reg   <= cfg_data;
                CFG_PERIOD:        period_us_reg  <= cfg_data;
                default:           ;
            endcase
        end
    end

    // architectural state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            window_sum_reg <= WSUM_RESET;
            slot_reg       <= '0;
            psum_reg       <= '0;
            tally_reg      <= '0;
            rate_reg       <= '0;
            mean_reg       <= '0;
        end else begin
            case (state_reg)
                ST_UPDATE: begin
                    // window always contains the evicted entry, so no underflow
                    window_sum_reg <= window_sum_reg - WSW'(old_entry) + WSW'(stored);
                    slot_reg       <= (slot_reg == AW'(HISTORY_DEPTH - 1)) ? '0
                                                                            : slot_reg + 1'b1;
                    psum_reg       <= psum_new;
                    tally_reg      <= tally_new;
                end
                ST_FPS_RUN: begin
                    if (div_stat.done) begin
                        rate_reg <= div_stat.quotient;
                    end
                end
                ST_MEAN_RUN: begin
                    if (div_stat.done) begin
                        mean_reg  <= div_stat.quotient;
                        psum_reg  <= '0;
                        tally_reg <= '0;
                    end
                end
                default: ;
            endcase
        end
    end

    // working registers
    always_ff @(posedge aclk) begin
        case (state_reg)
            ST_IDLE: begin
                if (in_accept) begin
                    frame_reg <= s_frame_us;
                end
            end
            ST_UPDATE: close_reg <= ({1'b0, psum_new} >= (PSUM_W+1)'(period_us_reg));
            ST_AVG:    avg_reg <= avg_calc;
            ST_MUL: product_reg <= (2*TALLY_W)'(tally_reg) * (2*TALLY_W)'(US_PER_S);
            default: ;
        endcase
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (state_reg == ST_OUTPUT && out_free) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == ST_OUTPUT && out_free) begin
            m_avg_reg  <= avg_reg;
            m_fps_reg  <= rate_reg;
            m_mean_reg <= mean_reg;
            m_done_reg <= close_reg;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_avg_delta_us  = m_avg_reg;
    assign m_fps_q8        = m_fps_reg;
    assign m_mean_frame_us = m_mean_reg;
    assign m_period_done   = m_done_reg;

endmodule

`default_nettype wire

// File: test/testbench.sv
// Self-checking testbench for frame_rate_meter_unit: history ring average and period statistics.
// Directed and random frame times under several register settings, checked against an inline predictor.
// Depends on frm_pkg and the frame_rate_meter_unit RTL.
`timescale 1ns / 100ps

module testbench;

    import frm_pkg::*;

    localparam int  CLK_HALF    = 4;
    localparam int  DEPTH       = HISTORY_DEPTH_DEF;
    localparam int  CYCLE_LIMIT = 3_000_000;
    localparam int  DRAIN_WAIT  = 120;
    localparam int  RAND_PHASES = 10;
    localparam int  PHASE_ITEMS = 65;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;
    localparam logic [FRAME_W-1:0]   FRAME_MAX  = '1;
    localparam logic [PSUM_W-1:0]    PSUM_SAT   = '1;
    localparam longint unsigned      FPS_SCALE  = 64'd256_000_000;

    typedef struct {
        logic [FRAME_W-1:0] avg_delta_us;
        logic [FRAME_W-1:0] fps_q8;
        logic [FRAME_W-1:0] mean_frame_us;
        logic               period_done;
    } meter_result_t;

    logic                 aclk            = 1'b0;
    logic                 aresetn         = 1'b0;
    logic                 s_valid         = 1'b0;
    logic                 s_ready;
    logic [FRAME_W-1:0]   s_frame_us      = '0;
    logic                 m_valid;
    logic                 m_ready         = 1'b0;
    logic [FRAME_W-1:0]   m_avg_delta_us;
    logic [FRAME_W-1:0]   m_fps_q8;
    logic [FRAME_W-1:0]   m_mean_frame_us;
    logic                 m_period_done;
    logic                 cfg_valid       = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index       = '0;
    logic [FRAME_W-1:0]   cfg_data        = '0;

    frame_rate_meter_unit u_top (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_frame_us      (s_frame_us),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_avg_delta_us  (m_avg_delta_us),
        .m_fps_q8        (m_fps_q8),
        .m_mean_frame_us (m_mean_frame_us),
        .m_period_done   (m_period_done),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data)
    );

    always #CLK_HALF aclk = ~aclk;

    // predictor state
    logic [FRAME_W-1:0] default_us = RESET_DEFAULT_US;
    logic [FRAME_W-1:0] clamp_us   = RESET_CLAMP_US;
    logic [FRAME_W-1:0] period_cfg = RESET_PERIOD_US;
    logic [FRAME_W-1:0] hist_ring [DEPTH];
    logic [28:0]        window_acc;
    int                 ring_slot;
    logic [PSUM_W-1:0]  period_acc;
    logic [TALLY_W-1:0] tally_acc;
    logic [FRAME_W-1:0] last_rate;
    logic [FRAME_W-1:0] last_mean;

    logic [FRAME_W-1:0] pending_frames [$];
    meter_result_t      expected_results [$];
    meter_result_t      oldest_expected;
    int                 mismatches  = 0;
    int                 cycle_count = 0;
    int                 gap_left    = 0;
    int                 stall_left  = 0;
    bit                 s_burst     = 1'b0;
    bit                 m_burst     = 1'b0;

    function automatic logic [FRAME_W-1:0] clip_to_frame(input longint unsigned v);
        return (v > longint'(FRAME_MAX)) ? FRAME_MAX : v[FRAME_W-1:0];
    endfunction

    // mostly short gaps, a few long ones
    function automatic int idle_length();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 70)
            return $urandom_range(0, 3);
        else if (pick < 95)
            return $urandom_range(4, 40);
        else
            return $urandom_range(41, 300);
    endfunction

    function automatic meter_result_t meter_step(input logic [FRAME_W-1:0] frame);
        logic [FRAME_W-1:0] kept;
        logic [PSUM_W:0]    psum_next;
        longint unsigned    num;
        meter_result_t      r;
        kept = (frame > clamp_us) ? default_us : frame;
        window_acc = window_acc - hist_ring[ring_slot] + kept;
        hist_ring[ring_slot] = kept;
        r.avg_delta_us = clip_to_frame(window_acc / DEPTH);
        ring_slot = (ring_slot + 1 >= DEPTH) ? 0 : ring_slot + 1;
        psum_next = period_acc + frame;
        period_acc = (psum_next > PSUM_SAT) ? PSUM_SAT : psum_next[PSUM_W-1:0];
        if (tally_acc != TALLY_MAX)
            tally_acc++;
        r.period_done = 1'b0;
        if (period_acc >= period_cfg) begin
            num = tally_acc;
            num = num * FPS_SCALE;
            last_rate = (period_acc == 0) ? FRAME_MAX : clip_to_frame(num / period_acc);
            last_mean = clip_to_frame(longint'(period_acc) / tally_acc);
            period_acc = '0;
            tally_acc = '0;
            r.period_done = 1'b1;
        end
        r.fps_q8 = last_rate;
        r.mean_frame_us = last_mean;
        return r;
    endfunction

    // frame request driver
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
            gap_left = 0;
        end else begin
            if (s_valid && s_ready) begin
                expected_results.push_back(meter_step(s_frame_us));
                if ($urandom_range(0, 31) == 0)
                    s_burst = !s_burst;
            end
            if (!s_valid || s_ready) begin
                if (gap_left != 0) begin
                    gap_left = gap_left - 1;
                    s_valid <= 1'b0;
                end else if (pending_frames.size() != 0) begin
                    s_valid <= 1'b1;
                    s_frame_us <= pending_frames.pop_front();
                    gap_left = s_burst ? 0 : idle_length();
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // result monitor with random backpressure
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
            stall_left = 0;
        end else begin
            if (m_valid && m_ready) begin
                if ($urandom_range(0, 31) == 0)
                    m_burst = !m_burst;
                if (expected_results.size() == 0) begin
                    $error("unexpected result: avg_delta_us %0d", m_avg_delta_us);
                    mismatches++;
                end else begin
                    oldest_expected = expected_results.pop_front();
                    if (m_avg_delta_us !== oldest_expected.avg_delta_us) begin
                        $error("avg_delta_us: expected %0d, actual %0d",
                               oldest_expected.avg_delta_us, m_avg_delta_us);
                        mismatches++;
                    end
                    if (m_fps_q8 !== oldest_expected.fps_q8) begin
                        $error("fps_q8: expected %0d, actual %0d",
                               oldest_expected.fps_q8, m_fps_q8);
                        mismatches++;
                    end
                    if (m_mean_frame_us !== oldest_expected.mean_frame_us) begin
                        $error("mean_frame_us: expected %0d, actual %0d",
                               oldest_expected.mean_frame_us, m_mean_frame_us);
                        mismatches++;
                    end
                    if (m_period_done !== oldest_expected.period_done) begin
                        $error("period_done: expected %0d, actual %0d",
                               oldest_expected.period_done, m_period_done);
                        mismatches++;
                    end
                end
            end
            if (stall_left != 0) begin
                stall_left = stall_left - 1;
                m_ready <= 1'b0;
            end else if (!m_burst && $urandom_range(0, 9) == 0) begin
                stall_left = idle_length();
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    // checked at the falling edge so the driver's updates have settled
    task automatic wait_drained();
        while (pending_frames.size() != 0 || s_valid || expected_results.size() != 0)
            @(negedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [FRAME_W-1:0] value);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            CFG_DEFAULT_FRAME: default_us = value;
            CFG_CLAMP_LIMIT:   clamp_us = value;
            CFG_PERIOD:        period_cfg = value;
            default: ;
        endcase
    endtask

    task automatic program_meter(input logic [FRAME_W-1:0] dflt, input logic [FRAME_W-1:0] clamp,
                                 input logic [FRAME_W-1:0] period);
        write_reg(CFG_DEFAULT_FRAME, dflt);
        write_reg(CFG_CLAMP_LIMIT, clamp);
        write_reg(CFG_PERIOD, period);
    endtask

    initial begin
        int                 kind;
        int                 pick;
        logic [FRAME_W-1:0] frame;

        for (int i = 0; i < DEPTH; i++)
            hist_ring[i] = RESET_DEFAULT_US;
        window_acc  = 29'(DEPTH * RESET_DEFAULT_US);
        ring_slot   = 0;
        period_acc  = '0;
        tally_acc   = '0;
        last_rate   = '0;
        last_mean   = '0;

        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        // reset settings: field extremes, clamp boundary, alternating bit patterns
        pending_frames = '{24'd0, 24'd1, FRAME_MAX, 24'd1000000, 24'd1000001,
                           24'hAAAAAA, 24'h555555};
        repeat (8) pending_frames.push_back(24'd33333);
        wait_drained();

        // zero clamp: every nonzero frame stored as default; tiny period saturates fps
        program_meter(24'd1, 24'd0, 24'd1);
        pending_frames = '{24'd0, 24'd0, 24'd5};
        wait_drained();

        // zero period with zero frame closes on an empty sum; unused index is ignored
        program_meter(24'd0, FRAME_MAX, 24'd0);
        write_reg(CFG_UNUSED, FRAME_MAX);
        pending_frames = '{24'd0, 24'd7};
        wait_drained();

        program_meter(FRAME_MAX, FRAME_MAX, FRAME_MAX);
        pending_frames = '{FRAME_MAX, FRAME_MAX, 24'd1};
        wait_drained();

        for (int p = 0; p < RAND_PHASES; p++) begin
            kind = (p == 0) ? 0 : $urandom_range(0, 3);
            case (kind)
                0: program_meter(FRAME_W'($urandom_range(8000, 50000)),
                                 FRAME_W'($urandom_range(60000, 400000)),
                                 FRAME_W'($urandom_range(200000, 2000000)));
                1: program_meter(FRAME_W'($urandom_range(0, FRAME_MAX)),
                                 FRAME_W'($urandom_range(0, FRAME_MAX)),
                                 FRAME_W'($urandom_range(0, FRAME_MAX)));
                2: program_meter(FRAME_W'($urandom_range(1, 100)),
                                 FRAME_W'($urandom_range(0, 200)),
                                 FRAME_W'($urandom_range(0, 2000)));
                default: program_meter(FRAME_W'($urandom_range(0, FRAME_MAX)),
                                       FRAME_W'($urandom_range(1000, 100000)),
                                       FRAME_W'($urandom_range(50000, 500000)));
            endcase
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                pick = $urandom_range(0, 99);
                if (pick < 70)
                    frame = FRAME_W'($urandom_range(1000, 100000));
                else if (pick < 80)
                    frame = FRAME_W'($urandom_range(0, FRAME_MAX));
                else if (pick < 85)
                    frame = '0;
                else if (pick < 88)
                    frame = FRAME_MAX;
                else if (pick < 94)
                    frame = clamp_us;
                else
                    frame = (clamp_us == FRAME_MAX) ? clamp_us : clamp_us + 1'b1;
                pending_frames.push_back(frame);
            end
            wait_drained();
        end

        repeat (DRAIN_WAIT) @(posedge aclk);
        if (mismatches == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
